// ----- src/ult_pkg.sv -----
// Shared types, constants and the microcode ROM of the unordered list table.
// Used by ult_sequencer, ult_datapath and unordered_list_table_unit.
`default_nettype none

package ult_pkg;

    localparam int CAPACITY   = 64;
    localparam int ITEM_WIDTH = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Request codes carried on the action port.
    localparam logic [2:0] ACT_INSERT   = 3'd0;
    localparam logic [2:0] ACT_DELETE   = 3'd1;
    localparam logic [2:0] ACT_RETRIEVE = 3'd2;
    localparam logic [2:0] ACT_CLEAR    = 3'd3;
    localparam logic [2:0] ACT_READ_IDX = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef logic [2:0] upc_t;

    // Microprogram addresses.
    localparam upc_t UPC_IDLE     = 3'd0;
    localparam upc_t UPC_INSERT   = 3'd1;
    localparam upc_t UPC_SCAN     = 3'd2;
    localparam upc_t UPC_DEL_MOVE = 3'd3;
    localparam upc_t UPC_CLEAR    = 3'd4;
    localparam upc_t UPC_INDEX    = 3'd5;
    localparam upc_t UPC_IGNORE   = 3'd6;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INSERT,
        OP_SCAN,
        OP_DEL_MOVE,
        OP_CLEAR,
        OP_INDEX,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        BR_JUMP,
        BR_DISPATCH,
        BR_SCAN
    } br_t;

    typedef struct packed {
        op_t  op;
        br_t  br;
        upc_t target;
    } ucode_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic is_delete;
    } seq_status_t;

    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        begin
            case (addr)
                UPC_IDLE:     w = '{op: OP_LOAD,     br: BR_DISPATCH, target: UPC_IDLE};
                UPC_INSERT:   w = '{op: OP_INSERT,   br: BR_JUMP,     target: UPC_IDLE};
                UPC_SCAN:     w = '{op: OP_SCAN,     br: BR_SCAN,     target: UPC_DEL_MOVE};
                UPC_DEL_MOVE: w = '{op: OP_DEL_MOVE, br: BR_JUMP,     target: UPC_IDLE};
                UPC_CLEAR:    w = '{op: OP_CLEAR,    br: BR_JUMP,     target: UPC_IDLE};
                UPC_INDEX:    w = '{op: OP_INDEX,    br: BR_JUMP,     target: UPC_IDLE};
                UPC_IGNORE:   w = '{op: OP_DONE,     br: BR_JUMP,     target: UPC_IDLE};
                default:      w = '{op: OP_IDLE,     br: BR_JUMP,     target: UPC_IDLE};
            endcase
            return w;
        end
    endfunction

    function automatic upc_t dispatch(input logic [2:0] action);
        upc_t t;
        begin
            case (action)
                ACT_INSERT:   t = UPC_INSERT;
                ACT_DELETE:   t = UPC_SCAN;
                ACT_RETRIEVE: t = UPC_SCAN;
                ACT_CLEAR:    t = UPC_CLEAR;
                ACT_READ_IDX: t = UPC_INDEX;
                default:      t = UPC_IGNORE;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/ult_sequencer.sv -----
// Microcode sequencer: step counter, control ROM lookup and branch logic.
// Depends on ult_pkg.
`default_nettype none

module ult_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [2:0]          action,
    input  wire ult_pkg::seq_status_t stat,
    output ult_pkg::ucode_t          ctrl,
    output logic                     busy
);
    import ult_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t word;

    assign word = ucode_rom(upc_reg);
    assign busy = (upc_reg != UPC_IDLE);

    always_comb
    begin
        case (word.br)
            BR_JUMP:     upc_next = word.target;
            BR_DISPATCH: upc_next = start ? dispatch(action) : upc_reg;
            BR_SCAN:
            begin
                // A delete hit goes on to the move step; any other outcome ends the search.
                if (stat.hit && stat.is_delete)
                    upc_next = word.target;
                else if (stat.hit || stat.miss)
                    upc_next = UPC_IDLE;
                else
                    upc_next = upc_reg;
            end
            default:     upc_next = UPC_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = word;
        if (word.br == BR_DISPATCH && !start)
            ctrl.op = OP_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UPC_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

`default_nettype wire

// ----- src/ult_datapath.sv -----
// Datapath: entry memory with valid bits, count, scan pointer and result registers.
// Depends on ult_pkg; driven by the control word from ult_sequencer.
`default_nettype none

module ult_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ult_pkg::ucode_t                  ctrl,
    input  wire logic [2:0]                       action,
    input  wire logic [ult_pkg::ITEM_WIDTH-1:0]   item_value,
    input  wire logic [5:0]                       slot_index,
    output ult_pkg::seq_status_t                  stat,
    output logic                                  done,
    output logic                                  found,
    output logic [ult_pkg::ITEM_WIDTH-1:0]        read_value,
    output logic [1:0]                            status,
    output logic [ult_pkg::CNT_W-1:0]             item_count,
    output logic                                  is_full,
    output logic                                  is_empty
);
    import ult_pkg::*;

    logic [ITEM_WIDTH-1:0] mem [CAPACITY];
    logic [CAPACITY-1:0]   valid_reg;
    logic [CAPACITY-1:0]   valid_next;

    logic [2:0]            act_reg,    act_next;
    logic [ITEM_WIDTH-1:0] value_reg,  value_next;
    logic [CNT_W-1:0]      ptr_reg,    ptr_next;
    logic [ADDR_W-1:0]     pos_reg,    pos_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic                  bad_reg,    bad_next;
    logic                  done_reg,   done_next;
    logic                  found_reg,  found_next;
    logic [ITEM_WIDTH-1:0] rv_reg,     rv_next;
    logic [1:0]            status_reg, status_next;

    logic [ITEM_WIDTH-1:0] rdata_reg;
    logic                  rvalid_reg;
    logic [ITEM_WIDTH-1:0] rdata_eff;

    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic                  clear_last;
    logic                  clear_all;
    logic [CNT_W-1:0]      last;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  scan_miss;
    logic                  scan_hit;

    // A slot that was never written since reset or since it was freed reads as zero.
    assign rdata_eff = rvalid_reg ? rdata_reg : '0;
    assign last      = count_reg - CNT_W'(1);
    assign rd_addr   = ptr_next[ADDR_W-1:0];
    assign scan_miss = (ptr_reg >= count_reg);
    assign scan_hit  = !scan_miss && (rdata_eff == value_reg);

    assign stat.hit       = (ctrl.op == OP_SCAN) && scan_hit;
    assign stat.miss      = (ctrl.op == OP_SCAN) && scan_miss;
    assign stat.is_delete = (act_reg == ACT_DELETE);

    always_comb
    begin
        act_next    = act_reg;
        value_next  = value_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        bad_next    = bad_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        rv_next     = rv_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = count_reg[ADDR_W-1:0];
        wdata       = value_reg;
        clear_last  = 1'b0;
        clear_all   = 1'b0;

        case (ctrl.op)
            OP_LOAD:
            begin
                act_next   = action;
                value_next = item_value;
                bad_next   = (32'(slot_index) >= 32'(CAPACITY));
                // Reading by index starts the memory read at the requested slot.
                if (action == ACT_READ_IDX)
                    ptr_next = CNT_W'(slot_index);
                else
                    ptr_next = '0;
            end
            OP_INSERT:
            begin
                done_next  = 1'b1;
                found_next = 1'b0;
                rv_next    = '0;
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    we          = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_SCAN:
            begin
                if (scan_miss)
                begin
                    done_next   = 1'b1;
                    found_next  = 1'b0;
                    rv_next     = '0;
                    status_next = ST_NOT_FOUND;
                end
                else if (scan_hit)
                begin
                    if (act_reg == ACT_DELETE)
                    begin
                        // Fetch the last entry so it can fill the hole.
                        pos_next = ptr_reg[ADDR_W-1:0];
                        ptr_next = last;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        found_next  = 1'b1;
                        rv_next     = value_reg;
                        status_next = ST_OK;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            OP_DEL_MOVE:
            begin
                we          = 1'b1;
                waddr       = pos_reg;
                wdata       = rdata_eff;
                clear_last  = 1'b1;
                count_next  = last;
                done_next   = 1'b1;
                found_next  = 1'b1;
                rv_next     = value_reg;
                status_next = ST_OK;
            end
            OP_CLEAR:
            begin
                clear_all   = 1'b1;
                count_next  = '0;
                done_next   = 1'b1;
                found_next  = 1'b0;
                rv_next     = '0;
                status_next = ST_OK;
            end
            OP_INDEX:
            begin
                done_next  = 1'b1;
                found_next = 1'b0;
                if (bad_reg)
                begin
                    rv_next     = '0;
                    status_next = ST_BAD_INDEX;
                end
                else
                begin
                    rv_next     = rdata_eff;
                    status_next = ST_OK;
                end
            end
            OP_DONE:
            begin
                done_next   = 1'b1;
                found_next  = 1'b0;
                rv_next     = '0;
                status_next = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg  <= mem[rd_addr];
        rvalid_reg <= valid_reg[rd_addr];
    end

    // When the deleted entry is the last one, clearing its valid bit must win.
    always_comb
    begin
        valid_next = valid_reg;
        if (clear_all)
        begin
            valid_next = '0;
        end
        else
        begin
            if (we)
                valid_next[waddr] = 1'b1;
            if (clear_last)
                valid_next[last[ADDR_W-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        value_reg  <= value_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        bad_reg    <= bad_next;
        found_reg  <= found_next;
        rv_reg     <= rv_next;
        status_reg <= status_next;
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = rv_reg;
    assign status     = status_reg;
    assign item_count = count_reg;
    assign is_full    = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty   = (count_reg == '0);

endmodule

`default_nettype wire

// ----- src/unordered_list_table_unit.sv -----
// Top level of the unordered list table: joins the microcode sequencer and the datapath.
// Depends on ult_pkg, ult_sequencer and ult_datapath.
//
// Usage:
//   A request transaction is taken at a rising edge where start is high and busy is low;
//   action, item_value and slot_index are sampled there. busy stays high while the
//   request is worked on.
//   Each request gives exactly one result transaction: done is high for one cycle and
//   found, read_value, status, item_count, is_full and is_empty are valid in that cycle.
//   busy is already low in that cycle, so a new request may be issued there.
// Steps, start edge to done:
//   insert, clear, read by index and unknown actions: the load step, then the action step.
//   retrieve: the load step, then the search, which compares entries up to the hit (at
//     most 64) or all count entries on a miss.
//   delete: as retrieve; a hit adds a move step that fills the hole with the last entry.
//   The search loop compares one entry per cycle against the single read port of
//   the entry memory, which sets the throughput.
// Reset: all entries read as zero and the count is zero right after rst_n; no sweep
//   is needed since every slot carries a valid bit.
// The receiver cannot stall: a result is shown for its single cycle only.
`default_nettype none

module unordered_list_table_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [2:0]                       action,
    input  wire logic [ult_pkg::ITEM_WIDTH-1:0]   item_value,
    input  wire logic [5:0]                       slot_index,
    output logic                                  done,
    output logic                                  found,
    output logic [ult_pkg::ITEM_WIDTH-1:0]        read_value,
    output logic [1:0]                            status,
    output logic [ult_pkg::CNT_W-1:0]             item_count,
    output logic                                  is_full,
    output logic                                  is_empty
);
    import ult_pkg::*;

    ucode_t      ctrl;
    seq_status_t stat;

    ult_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    ult_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .action     (action),
        .item_value (item_value),
        .slot_index (slot_index),
        .stat       (stat),
        .done       (done),
        .found      (found),
        .read_value (read_value),
        .status     (status),
        .item_count (item_count),
        .is_full    (is_full),
        .is_empty   (is_empty)
    );

endmodule

`default_nettype wire
